// File: rtl/core/swsnd_pkg.sv
package swsnd_pkg;

  // default sizes of the sequence space and the data word
  localparam int unsigned SeqBitsDef = 3;
  localparam int unsigned PayloadBitsDef = 32;

  // window length register
  localparam int unsigned WlenBits = 3;
  localparam logic [WlenBits-1:0] WlenReset = 3'd4;

  // duplicate ack counter
  localparam int unsigned DupBits = 2;
  localparam logic [DupBits-1:0] DupLimit = 2'd3;

  typedef enum logic [1:0] {
    FUNC_SEND    = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_TIMEOUT = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

endpackage

// File: rtl/core/swsnd_queue.sv
module swsnd_queue #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [DataW-1:0] pop_data_o
);

  logic [DataW-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/swsnd_front.sv
module swsnd_front
  import swsnd_pkg::*;
#(
  parameter int unsigned SeqBits = SeqBitsDef,
  parameter int unsigned PayloadBits = PayloadBitsDef,
  localparam int unsigned EntW = 3 * SeqBits + PayloadBits + 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [WlenBits-1:0]    cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             func_i,
  input  logic [PayloadBits-1:0] payload_i,
  input  logic [SeqBits-1:0]     ack_number_i,
  input  logic                   ack_checksum_ok_i,
  input  logic [SeqBits-1:0]     expired_seq_i,
  output logic                   push_o,
  output logic [EntW-1:0]        push_data_o,
  input  logic                   full_i
);

  // compare width that holds both the window length and a sequence count
  localparam int unsigned CmpW = (SeqBits > WlenBits) ? SeqBits : WlenBits;
  localparam logic [SeqBits-1:0] SeqOne = SeqBits'(1);
  localparam logic [CmpW-1:0] SeqMaskW = CmpW'({SeqBits{1'b1}});

  typedef struct packed {
    logic                   full;
    logic [SeqBits-1:0]     stas;
    logic                   sta;
    logic [SeqBits-1:0]     stps;
    logic                   stp;
    logic [PayloadBits-1:0] pay;
    logic                   from_store;
    logic [SeqBits-1:0]     txs;
    logic                   txv;
    logic                   acc;
  } ent_t;

  logic [WlenBits-1:0] wlen_q;
  logic [SeqBits-1:0]  next_seq_q, next_seq_d;
  logic [SeqBits-1:0]  base_q, base_d;
  logic [DupBits-1:0]  dup_q, dup_d;
  logic [DupBits-1:0]  dup_inc;
  logic [CmpW-1:0]     limit;
  logic [SeqBits-1:0]  outst, outst_new, ack_off, base_prev;
  logic                full_now, accept;
  func_e               func;
  ent_t                ent;

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign push_o     = accept;
  assign func       = func_e'(func_i);

  // clamp the window length to the sequence space
  assign limit     = (CmpW'(wlen_q) > SeqMaskW) ? SeqMaskW : CmpW'(wlen_q);
  assign outst     = next_seq_q - base_q;
  assign full_now  = CmpW'(outst) >= limit;
  assign ack_off   = ack_number_i - base_q;
  assign base_prev = base_q - SeqOne;
  assign dup_inc   = dup_q + DupBits'(1);
  assign outst_new = next_seq_d - base_d;

  always_comb begin
    next_seq_d     = next_seq_q;
    base_d         = base_q;
    dup_d          = dup_q;
    ent            = '0;
    unique case (func)
      FUNC_SEND: begin
        if (!full_now) begin
          ent.acc = 1'b1;
          ent.txv = 1'b1;
          ent.txs = next_seq_q;
          ent.pay = payload_i;
          if (base_q == next_seq_q) begin
            ent.sta  = 1'b1;
            ent.stas = next_seq_q;
          end
          next_seq_d = next_seq_q + SeqOne;
        end
      end
      FUNC_ACK: begin
        if (ack_checksum_ok_i) begin
          if (ack_off < outst) begin
            base_d   = ack_number_i + SeqOne;
            ent.stp  = 1'b1;
            ent.stps = base_q;
            if (base_d != next_seq_q) begin
              ent.sta  = 1'b1;
              ent.stas = base_d;
            end
            dup_d = DupBits'(1);
          end else if (ack_number_i == base_prev && dup_q < DupLimit) begin
            dup_d = dup_inc;
            // duplicate count reaching DupLimit: resend the oldest packet
            if (dup_inc == DupLimit && base_q != next_seq_q) begin
              ent.txv        = 1'b1;
              ent.txs        = base_q;
              ent.from_store = 1'b1;
              ent.stp        = 1'b1;
              ent.stps       = base_q;
              ent.sta        = 1'b1;
              ent.stas       = base_q;
              dup_d          = '0;
            end
          end
        end
      end
      FUNC_TIMEOUT: begin
        ent.txv        = 1'b1;
        ent.txs        = expired_seq_i;
        ent.from_store = 1'b1;
        ent.stp        = 1'b1;
        ent.stps       = expired_seq_i;
        ent.sta        = 1'b1;
        ent.stas       = base_q;
      end
      default: begin
      end
    endcase
    ent.full = CmpW'(outst_new) >= limit;
  end

  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q     <= WlenReset;
      next_seq_q <= '0;
      base_q     <= '0;
      dup_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
      if (accept) begin
        next_seq_q <= next_seq_d;
        base_q     <= base_d;
        dup_q      <= dup_d;
      end
    end
  end

endmodule

// File: rtl/core/swsnd_back.sv
module swsnd_back
  import swsnd_pkg::*;
#(
  parameter int unsigned SeqBits = SeqBitsDef,
  parameter int unsigned PayloadBits = PayloadBitsDef,
  localparam int unsigned EntW = 3 * SeqBits + PayloadBits + 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  logic [EntW-1:0]        pop_data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   send_accepted_o,
  output logic                   tx_valid_o,
  output logic [SeqBits-1:0]     tx_seq_o,
  output logic [PayloadBits-1:0] tx_payload_o,
  output logic                   timer_stop_o,
  output logic [SeqBits-1:0]     timer_stop_seq_o,
  output logic                   timer_start_o,
  output logic [SeqBits-1:0]     timer_start_seq_o,
  output logic                   window_full_o
);

  localparam int unsigned Depth = 1 << SeqBits;

  typedef struct packed {
    logic                   full;
    logic [SeqBits-1:0]     stas;
    logic                   sta;
    logic [SeqBits-1:0]     stps;
    logic                   stp;
    logic [PayloadBits-1:0] pay;
    logic                   from_store;
    logic [SeqBits-1:0]     txs;
    logic                   txv;
    logic                   acc;
  } ent_t;

  logic [PayloadBits-1:0] store_mem [Depth];
  logic [PayloadBits-1:0] rd_q;
  ent_t                   head, out_q;
  logic                   out_valid_q;

  assign head  = ent_t'(pop_data_i);
  // advance when the output word is empty or being taken
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  // entries leave the queue in order, so a resend always sees earlier writes
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head;
      if (head.acc) begin
        store_mem[head.txs] <= head.pay;
      end
      rd_q <= store_mem[head.txs];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign send_accepted_o   = out_q.acc;
  assign tx_valid_o        = out_q.txv;
  assign tx_seq_o          = out_q.txs;
  assign tx_payload_o      = out_q.from_store ? rd_q : out_q.pay;
  assign timer_stop_o      = out_q.stp;
  assign timer_stop_seq_o  = out_q.stps;
  assign timer_start_o     = out_q.sta;
  assign timer_start_seq_o = out_q.stas;
  assign window_full_o     = out_q.full;

endmodule

// File: rtl/core/sliding_window_sender.sv
// Sender side of a cumulative-ack sliding window with fast retransmit.
// Input stream (s_axis): one word per event; tuser carries the event kind
// (send request, ack arrival, timer expiry), tdata the payload, ack number,
// ack checksum flag and expired sequence number.
// Output stream (m_axis): exactly one word per input word, in order, with the
// send verdict, the packet to transmit, timer stop/start commands and the
// window-full flag after the event.
// cfg_we_i/cfg_wdata_i write the window length; write it only while idle.
// Throughput: one word per cycle while m_axis is ready. The front end updates
// the window state in the cycle a word is accepted; a two-entry queue feeds
// the back end, which owns the packet store (one write or one registered read
// per word). An accepted word is written into the queue, then registered into
// the back end's output word on m_axis. A stall on m_axis holds the output
// word; the queue absorbs two more words before s_axis_tready drops.
// Reset clears the sequence state and loads a window length of 4; the packet
// store is not cleared and an entry reads valid only after it was sent once.
module sliding_window_sender
  import swsnd_pkg::*;
#(
  parameter int unsigned SeqBits = SeqBitsDef,
  parameter int unsigned PayloadBits = PayloadBitsDef,
  localparam int unsigned InRawW = PayloadBits + 2 * SeqBits + 1,
  localparam int unsigned InW = ((InRawW + 7) / 8) * 8,
  localparam int unsigned OutRawW = PayloadBits + 3 * SeqBits + 5,
  localparam int unsigned OutW = ((OutRawW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WlenBits-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: payload, ack_number, ack_checksum_ok, expired_seq
  input  logic [InW-1:0]      s_axis_tdata,
  // tuser: func
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: send_accepted, tx_valid, tx_seq, tx_payload, timer_stop,
  //        timer_stop_seq, timer_start, timer_start_seq, window_full
  output logic [OutW-1:0]     m_axis_tdata
);

  localparam int unsigned EntW = 3 * SeqBits + PayloadBits + 6;

  logic                   push, q_full, pop, q_empty;
  logic [EntW-1:0]        push_data, pop_data;
  logic                   acc, txv, stp, sta, wfull;
  logic [SeqBits-1:0]     txs, stps, stas;
  logic [PayloadBits-1:0] txp;

  swsnd_front #(
    .SeqBits    (SeqBits),
    .PayloadBits(PayloadBits)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .func_i           (s_axis_tuser),
    .payload_i        (s_axis_tdata[PayloadBits-1:0]),
    .ack_number_i     (s_axis_tdata[PayloadBits +: SeqBits]),
    .ack_checksum_ok_i(s_axis_tdata[PayloadBits+SeqBits]),
    .expired_seq_i    (s_axis_tdata[PayloadBits+SeqBits+1 +: SeqBits]),
    .push_o           (push),
    .push_data_o      (push_data),
    .full_i           (q_full)
  );

  swsnd_queue #(
    .DataW(EntW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_data_o (pop_data)
  );

  swsnd_back #(
    .SeqBits    (SeqBits),
    .PayloadBits(PayloadBits)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (q_empty),
    .pop_data_i       (pop_data),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .send_accepted_o  (acc),
    .tx_valid_o       (txv),
    .tx_seq_o         (txs),
    .tx_payload_o     (txp),
    .timer_stop_o     (stp),
    .timer_stop_seq_o (stps),
    .timer_start_o    (sta),
    .timer_start_seq_o(stas),
    .window_full_o    (wfull)
  );

  assign m_axis_tdata = OutW'({wfull, stas, sta, stps, stp, txp, txs, txv, acc});

endmodule

// File: sim/tb_sliding_window_sender.sv
`timescale 1ns / 1ps

module tb_sliding_window_sender
  import swsnd_pkg::*;
;

  localparam int unsigned SeqBits = SeqBitsDef;
  localparam int unsigned PayloadBits = PayloadBitsDef;
  localparam int unsigned InW = 40;
  localparam int unsigned OutW = 48;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseEvents = 200;

  // result word, lowest field last
  typedef struct packed {
    logic                   win_full;
    logic [SeqBits-1:0]     start_seq;
    logic                   start;
    logic [SeqBits-1:0]     stop_seq;
    logic                   stop;
    logic [PayloadBits-1:0] tx_pay;
    logic [SeqBits-1:0]     tx_seq;
    logic                   tx_v;
    logic                   accepted;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [WlenBits-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = FUNC_NONE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;

  sliding_window_sender u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sender window shadow
  logic [WlenBits-1:0]    win_len = WlenReset;
  logic [SeqBits-1:0]     win_next = '0;
  logic [SeqBits-1:0]     win_base = '0;
  logic [DupBits-1:0]     dup_seen = '0;
  logic [PayloadBits-1:0] sent_words [2**SeqBits];
  logic                   sent_mark [2**SeqBits] = '{default: 1'b0};

  verdict_t verdict_q [$];
  verdict_t want, got;

  bit quiet = 1'b0;
  int rx_wait = 0;
  int idle_cycles = 0;
  int errors = 0;
  int events_total = 0, sends_taken = 0, sends_refused = 0;
  int fast_resends = 0, expiries = 0, words_checked = 0;
  int unsigned phase_windows [8] = '{1, 7, 3, 5, 2, 6, 4, 7};

  function automatic logic [SeqBits-1:0] in_flight();
    return win_next - win_base;
  endfunction

  // advance the shadow window by one event and return the word it yields
  function automatic verdict_t window_step(input func_e f, input logic [PayloadBits-1:0] pay,
                                           input logic [SeqBits-1:0] ack, input logic ok,
                                           input logic [SeqBits-1:0] expired);
    verdict_t v;
    logic [SeqBits-1:0] off;
    v = '0;
    case (f)
      FUNC_SEND: begin
        if (in_flight() < win_len) begin
          v.accepted = 1'b1;
          v.tx_v = 1'b1;
          v.tx_seq = win_next;
          v.tx_pay = pay;
          sent_words[win_next] = pay;
          sent_mark[win_next] = 1'b1;
          if (win_base == win_next) begin
            v.start = 1'b1;
            v.start_seq = win_next;
          end
          win_next = win_next + 1'b1;
          sends_taken++;
        end else begin
          sends_refused++;
        end
      end
      FUNC_ACK: begin
        if (ok) begin
          off = ack - win_base;
          if (off < in_flight()) begin
            v.stop = 1'b1;
            v.stop_seq = win_base;
            win_base = ack + 1'b1;
            if (win_base != win_next) begin
              v.start = 1'b1;
              v.start_seq = win_base;
            end
            dup_seen = DupBits'(1);
          end else if (ack == win_base - 1'b1 && dup_seen < DupLimit) begin
            dup_seen++;
            if (dup_seen == DupLimit && win_base != win_next) begin
              v.tx_v = 1'b1;
              v.tx_seq = win_base;
              v.tx_pay = sent_words[win_base];
              v.stop = 1'b1;
              v.stop_seq = win_base;
              v.start = 1'b1;
              v.start_seq = win_base;
              dup_seen = '0;
              fast_resends++;
            end
          end
        end
      end
      FUNC_TIMEOUT: begin
        v.tx_v = 1'b1;
        v.tx_seq = expired;
        v.tx_pay = sent_words[expired];
        v.stop = 1'b1;
        v.stop_seq = expired;
        v.start = 1'b1;
        v.start_seq = win_base;
        expiries++;
      end
      default: ;
    endcase
    v.win_full = (in_flight() >= win_len);
    return v;
  endfunction

  // drive one word on s_axis and log its prediction once taken
  task automatic push_event(input func_e f, input logic [PayloadBits-1:0] pay,
                            input logic [SeqBits-1:0] ack, input logic ok,
                            input logic [SeqBits-1:0] expired);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= f;
    s_axis_tdata <= {1'b0, expired, ok, ack, pay};
    do @(posedge clk_i); while (!s_axis_tready);
    verdict_q.push_back(window_step(f, pay, ack, ok, expired));
    events_total++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [WlenBits-1:0] len);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_len = len;
  endtask

  function automatic logic [SeqBits-1:0] any_sent_seq();
    logic [SeqBits-1:0] s;
    do s = SeqBits'($urandom); while (!sent_mark[s]);
    return s;
  endfunction

  // duplicates on an empty window count up and saturate without a resend
  task automatic test_idle_acks();
    repeat (4) push_event(FUNC_ACK, $urandom(), 3'd7, 1'b1, 3'($urandom));
    push_event(FUNC_NONE, $urandom(), 3'($urandom), 1'($urandom), 3'($urandom));
  endtask

  task automatic test_fill_window();
    push_event(FUNC_SEND, 32'h0000_0000, 3'd0, 1'b0, 3'd0);
    push_event(FUNC_SEND, 32'hffff_ffff, 3'd7, 1'b1, 3'd7);
    push_event(FUNC_SEND, 32'h5a5a_a5a5, 3'($urandom), 1'($urandom), 3'($urandom));
    push_event(FUNC_SEND, $urandom(), 3'($urandom), 1'($urandom), 3'($urandom));
    push_event(FUNC_SEND, $urandom(), 3'($urandom), 1'($urandom), 3'($urandom));
  endtask

  // new ack, two duplicates firing the fast resend, out-of-window ack, bad checksum
  task automatic test_ack_handling();
    push_event(FUNC_ACK, $urandom(), 3'd1, 1'b1, 3'($urandom));
    push_event(FUNC_ACK, $urandom(), 3'd1, 1'b1, 3'($urandom));
    push_event(FUNC_ACK, $urandom(), 3'd1, 1'b1, 3'($urandom));
    push_event(FUNC_ACK, $urandom(), 3'd5, 1'b1, 3'($urandom));
    push_event(FUNC_ACK, $urandom(), 3'd3, 1'b0, 3'($urandom));
  endtask

  // expiry of an outstanding, an acknowledged, and (window empty) an old packet
  task automatic test_timer_expiry();
    push_event(FUNC_TIMEOUT, $urandom(), 3'($urandom), 1'($urandom), 3'd3);
    push_event(FUNC_TIMEOUT, $urandom(), 3'($urandom), 1'($urandom), 3'd0);
    push_event(FUNC_ACK, $urandom(), 3'd3, 1'b1, 3'($urandom));
    push_event(FUNC_TIMEOUT, $urandom(), 3'($urandom), 1'($urandom), 3'd1);
  endtask

  task automatic test_window_extremes();
    set_window('0);
    push_event(FUNC_SEND, $urandom(), 3'($urandom), 1'($urandom), 3'($urandom));
    set_window('1);
    repeat (8) push_event(FUNC_SEND, $urandom(), 3'($urandom), 1'($urandom), 3'($urandom));
    push_event(FUNC_ACK, $urandom(), win_next - 1'b1, 1'b1, 3'($urandom));
  endtask

  // mostly well-formed traffic: send bursts, in-window acks, duplicate runs,
  // expiries of sent packets; the rest is stray acks and idle kinds
  task automatic test_random_traffic();
    int phase, n, pick;
    logic [SeqBits-1:0] fl, seq;
    for (phase = 0; phase < 8; phase++) begin
      set_window(WlenBits'(phase_windows[phase]));
      quiet = (phase % 3 == 2);
      n = 0;
      while (n < PhaseEvents) begin
        pick = $urandom_range(0, 99);
        fl = in_flight();
        if (pick < 38) begin
          repeat ($urandom_range(1, 4)) begin
            push_event(FUNC_SEND, $urandom(), 3'($urandom), 1'($urandom), 3'($urandom));
            n++;
          end
        end else if (pick < 58 && fl != 0) begin
          push_event(FUNC_ACK, $urandom(), win_base + 3'($urandom_range(0, fl - 1)), 1'b1,
                     3'($urandom));
          n++;
        end else if (pick < 74) begin
          repeat ($urandom_range(1, 3)) begin
            push_event(FUNC_ACK, $urandom(), win_base - 1'b1, 1'b1, 3'($urandom));
            n++;
          end
        end else if (pick < 86 && sends_taken != 0) begin
          if (fl != 0 && $urandom_range(0, 1) == 1)
            seq = win_base + 3'($urandom_range(0, fl - 1));
          else
            seq = any_sent_seq();
          push_event(FUNC_TIMEOUT, $urandom(), 3'($urandom), 1'($urandom), seq);
          n++;
        end else begin
          case ($urandom_range(0, 2))
            0: push_event(FUNC_NONE, $urandom(), 3'($urandom), 1'($urandom), 3'($urandom));
            1: push_event(FUNC_ACK, $urandom(), 3'($urandom), 1'b0, 3'($urandom));
            default: begin
              push_event(FUNC_ACK, $urandom(), 3'($urandom), 1'b1, 3'($urandom));
              n++;
            end
          endcase
        end
      end
    end
    quiet = 1'b0;
  endtask

  // receiver: after each word hold tready low for a random number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wait = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) rx_wait = quiet ? 0 : $urandom_range(0, 5);
      else if (rx_wait != 0) rx_wait--;
      m_axis_tready <= (rx_wait == 0);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected word, expected none got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        got = verdict_t'(m_axis_tdata[$bits(verdict_t)-1:0]);
        words_checked++;
        check_field("send_accepted", want.accepted, got.accepted);
        check_field("tx_valid", want.tx_v, got.tx_v);
        check_field("tx_seq", want.tx_seq, got.tx_seq);
        check_field("tx_payload", want.tx_pay, got.tx_pay);
        check_field("timer_stop", want.stop, got.stop);
        check_field("timer_stop_seq", want.stop_seq, got.stop_seq);
        check_field("timer_start", want.start, got.start);
        check_field("timer_start_seq", want.start_seq, got.start_seq);
        check_field("window_full", want.win_full, got.win_full);
        check_field("pad bits", '0, m_axis_tdata[OutW-1:$bits(verdict_t)]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("[sliding_window_sender] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_acks();
    test_fill_window();
    test_ack_handling();
    test_timer_expiry();
    test_window_extremes();
    test_random_traffic();
    wait_drained();
    $display("Checked %0d words from %0d events over window lengths 0 to 7.",
             words_checked, events_total);
    $display("Sends taken %0d, refused %0d; fast resends %0d; timer expiries %0d.",
             sends_taken, sends_refused, fast_resends, expiries);
    if (errors == 0)
      $display("[sliding_window_sender] OK");
    else
      $display("[sliding_window_sender] ERROR");
    $finish;
  end

endmodule
